// File: design/coi_pkg.sv
package coi_pkg;

    localparam int VALUE_W     = 8;
    localparam int POS_W       = 10;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 11;

    localparam logic signed [VALUE_W-1:0] OBSTACLE_VALUE = 8'sd100;
    localparam logic [CFG_DATA_W-1:0]     SIZE_RESET     = 11'd1024;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_GRID_WIDTH  = 2'd0,
        CFG_GRID_HEIGHT = 2'd1
    } cfg_index_t;

endpackage

// File: design/coi_if.sv
interface coi_cell_if;
    import coi_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] cell_value;
    logic                      frame_start;

    modport source (output valid, output cell_value, output frame_start, input ready);
    modport sink   (input valid, input cell_value, input frame_start, output ready);
endinterface

interface coi_result_if;
    import coi_pkg::*;

    logic             valid;
    logic             ready;
    logic             blocked;
    logic [POS_W-1:0] out_column;
    logic [POS_W-1:0] out_row;
    logic             last_cell;

    modport source (output valid, output blocked, output out_column, output out_row,
                    output last_cell, input ready);
    modport sink   (input valid, input blocked, input out_column, input out_row,
                    input last_cell, output ready);
endinterface

interface coi_cfg_if;
    import coi_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: design/coi_line_store.sv
module coi_line_store #(
    parameter int DEPTH = 1024,
    parameter int DW    = 4
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DW-1:0]            rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DW-1:0]            wr_data
);
    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] q_reg;
    logic          bypass_reg;
    logic [DW-1:0] bypass_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            q_reg           <= mem[rd_addr];
            bypass_data_reg <= wr_data;
        end
    end

    // A read that meets a write to the same column returns the new data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bypass_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            bypass_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    assign rd_data = bypass_reg ? bypass_data_reg : q_reg;

endmodule

// File: design/coi_ring_window.sv
module coi_ring_window #(
    parameter int RADIUS = 2,
    parameter int WW     = 11,
    parameter int CW     = 10,
    parameter int HW     = 11,
    parameter int ORW    = 10
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                shift_en,
    input  logic [2*RADIUS:0]   col_vec,
    input  logic [CW-1:0]       out_col,
    input  logic [ORW-1:0]      out_row,
    input  logic [WW-1:0]       eff_w,
    input  logic [HW-1:0]       eff_h,
    output logic                blocked
);
    localparam int N = 2 * RADIUS + 1;

    logic [N-1:0]          win_reg  [N];
    logic [N-1:0]          win_next [N];
    logic signed [WW+1:0]  col_pos  [N];
    logic signed [HW+1:0]  row_pos  [N];
    logic [N-1:0]          col_ok;
    logic [N-1:0]          row_ok;

    // Slot j holds the column RADIUS-j to the right of the centre; bit i of a
    // slot is the row RADIUS-i below the centre.
    always_comb
    begin
        win_next[0] = col_vec;
        for (int j = 1; j < N; j++)
        begin
            win_next[j] = win_reg[j-1];
        end
        for (int j = 0; j < N; j++)
        begin
            col_pos[j] = $signed((WW+2)'(out_col)) + (WW+2)'(RADIUS - j);
            col_ok[j]  = !col_pos[j][WW+1] && (col_pos[j] < $signed((WW+2)'(eff_w)));
            row_pos[j] = $signed((HW+2)'(out_row)) + (HW+2)'(RADIUS - j);
            row_ok[j]  = !row_pos[j][HW+1] && (row_pos[j] < $signed((HW+2)'(eff_h)));
        end
        blocked = win_next[RADIUS][RADIUS];
        for (int j = 0; j < N; j++)
        begin
            for (int i = 0; i < N; i++)
            begin
                if ((i == 0) || (i == N - 1) || (j == 0) || (j == N - 1))
                begin
                    blocked = blocked | (win_next[j][i] & col_ok[j] & row_ok[i]);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < N; j++)
            begin
                win_reg[j] <= '0;
            end
        end
        else if (shift_en)
        begin
            for (int j = 0; j < N; j++)
            begin
                win_reg[j] <= win_next[j];
            end
        end
    end

endmodule

// File: design/costmap_obstacle_inflation.sv
// Obstacle inflation of an occupancy grid streamed in raster order.
// The cells channel takes one beat per grid cell; frame_start marks the first
// cell of a grid. The results channel gives one beat per grid cell with its
// inflated blocked flag, its column and row, and last_cell on the final one.
// A result belongs to the input beat that comes RADIUS rows plus RADIUS cells
// later, so the host sends that many filler beats after the grid.
// The cfg channel writes grid_width (index 0) and grid_height (index 1); it is
// always ready; the host must write it only while the block is idle, which the
// block does not enforce. Throughput is one cell per cycle while the receiver
// does not stall: a line store with one read and one write port per cycle
// holds 2*RADIUS rows of obstacle bits, and the ring is evaluated on a register
// window in the cycle after the input register. A result beat passes the input
// register and then the result register. When the receiver stalls, the result
// register holds its beat, the stage behind it holds one more cell and then the
// cells channel drops ready. Reset clears the window, the counters and the
// valid flags, and sets both size registers to 1024; no clearing pass over the
// line store is needed, since stale rows are masked out by position.
module costmap_obstacle_inflation #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int RADIUS     = 2
) (
    input  logic         clk,
    input  logic         rst_n,
    coi_cfg_if.sink      cfg,
    coi_cell_if.sink     cells,
    coi_result_if.source results
);
    import coi_pkg::*;

    localparam int N           = 2 * RADIUS + 1;
    localparam int DW          = 2 * RADIUS;
    localparam int WW          = $clog2(MAX_WIDTH + 1);
    localparam int HW          = $clog2(MAX_HEIGHT + 1);
    localparam int CW          = $clog2(MAX_WIDTH);
    localparam int ORW         = $clog2(MAX_HEIGHT);
    localparam int COUNT_LIMIT = MAX_WIDTH * MAX_HEIGHT + RADIUS * MAX_WIDTH + RADIUS + 1;
    localparam int KW          = $clog2(COUNT_LIMIT + 1);

    logic [CFG_DATA_W-1:0] width_reg;
    logic [CFG_DATA_W-1:0] height_reg;
    logic [WW-1:0]         eff_w;
    logic [HW-1:0]         eff_h;
    logic [KW-1:0]         lag_reg;
    logic [KW-1:0]         cells_reg;

    logic                  accept;
    logic [KW-1:0]         k_in;
    logic [CW-1:0]         ck;
    logic [KW-1:0]         count_reg;
    logic [KW-1:0]         count_next;
    logic [CW-1:0]         col_reg;
    logic [CW-1:0]         col_next;

    logic                  s1_valid_reg;
    logic                  s1_obst_reg;
    logic [CW-1:0]         s1_col_reg;
    logic [KW-1:0]         s1_k_reg;
    logic                  s1_frame_reg;
    logic                  s1_fire;
    logic                  s1_emit;
    logic [KW-1:0]         s1_offset;

    logic [CW-1:0]         oc_reg;
    logic [CW-1:0]         oc_next;
    logic [ORW-1:0]        or_reg;
    logic [ORW-1:0]        or_next;
    logic                  last_now;

    logic [DW-1:0]         line_rd;
    logic [DW-1:0]         line_wr;
    logic [N-1:0]          col_vec;
    logic                  blocked_now;

    logic                  res_valid_reg;
    logic                  res_valid_next;
    logic                  res_blocked_reg;
    logic [POS_W-1:0]      res_col_reg;
    logic [POS_W-1:0]      res_row_reg;
    logic                  res_last_reg;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        if (width_reg == '0)
        begin
            eff_w = WW'(1);
        end
        else if (int'(width_reg) > MAX_WIDTH)
        begin
            eff_w = WW'(MAX_WIDTH);
        end
        else
        begin
            eff_w = WW'(width_reg);
        end
        if (height_reg == '0)
        begin
            eff_h = HW'(1);
        end
        else if (int'(height_reg) > MAX_HEIGHT)
        begin
            eff_h = HW'(MAX_HEIGHT);
        end
        else
        begin
            eff_h = HW'(height_reg);
        end
    end

    // Input side: position of the accepted cell in the current grid.
    assign accept   = cells.valid && cells.ready;
    assign k_in     = cells.frame_start ? '0 : count_reg;
    assign ck       = cells.frame_start ? '0 : col_reg;
    assign col_next = (WW'(ck) >= eff_w - WW'(1)) ? '0 : ck + CW'(1);
    assign count_next = (k_in == KW'(COUNT_LIMIT)) ? k_in : k_in + KW'(1);

    assign s1_fire     = s1_valid_reg && (!res_valid_reg || results.ready);
    assign cells.ready = !s1_valid_reg || s1_fire;

    assign s1_offset = s1_k_reg - lag_reg;
    assign s1_emit   = (s1_k_reg >= lag_reg) && (s1_offset < cells_reg);

    assign line_wr = {line_rd[DW-2:0], s1_obst_reg};
    assign col_vec = {line_rd, s1_obst_reg};

    coi_line_store #(
        .DEPTH (MAX_WIDTH),
        .DW    (DW)
    ) u_line_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (ck),
        .rd_data (line_rd),
        .wr_en   (s1_fire),
        .wr_addr (s1_col_reg),
        .wr_data (line_wr)
    );

    coi_ring_window #(
        .RADIUS (RADIUS),
        .WW     (WW),
        .CW     (CW),
        .HW     (HW),
        .ORW    (ORW)
    ) u_ring_window (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (s1_fire),
        .col_vec  (col_vec),
        .out_col  (oc_reg),
        .out_row  (or_reg),
        .eff_w    (eff_w),
        .eff_h    (eff_h),
        .blocked  (blocked_now)
    );

    // Output position advances once per emitted cell and restarts with a grid.
    always_comb
    begin
        oc_next = oc_reg;
        or_next = or_reg;
        if (s1_frame_reg)
        begin
            oc_next = '0;
            or_next = '0;
        end
        else if (s1_emit)
        begin
            if (WW'(oc_reg) >= eff_w - WW'(1))
            begin
                oc_next = '0;
                or_next = or_reg + ORW'(1);
            end
            else
            begin
                oc_next = oc_reg + CW'(1);
            end
        end
    end

    assign last_now = (WW'(oc_reg) == eff_w - WW'(1)) && (HW'(or_reg) == eff_h - HW'(1));

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (s1_fire && s1_emit)
        begin
            res_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= SIZE_RESET;
            height_reg    <= SIZE_RESET;
            count_reg     <= '0;
            col_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            oc_reg        <= '0;
            or_reg        <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    CFG_GRID_WIDTH:  width_reg  <= cfg.data;
                    CFG_GRID_HEIGHT: height_reg <= cfg.data;
                    default:
                    begin
                    end
                endcase
            end
            if (accept)
            begin
                count_reg <= count_next;
                col_reg   <= col_next;
            end
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_fire)
            begin
                oc_reg <= oc_next;
                or_reg <= or_next;
            end
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lag_reg   <= KW'(RADIUS) * KW'(eff_w) + KW'(RADIUS);
        cells_reg <= KW'(eff_w) * KW'(eff_h);
        if (accept)
        begin
            s1_obst_reg  <= (cells.cell_value == OBSTACLE_VALUE);
            s1_col_reg   <= ck;
            s1_k_reg     <= k_in;
            s1_frame_reg <= cells.frame_start;
        end
        if (s1_fire && s1_emit)
        begin
            res_blocked_reg <= blocked_now;
            res_col_reg     <= POS_W'(oc_reg);
            res_row_reg     <= POS_W'(or_reg);
            res_last_reg    <= last_now;
        end
    end

    assign results.valid      = res_valid_reg;
    assign results.blocked    = res_blocked_reg;
    assign results.out_column = res_col_reg;
    assign results.out_row    = res_row_reg;
    assign results.last_cell  = res_last_reg;

`ifndef ASSERT_OFF
    a_ready_low_means_full: assert property (@(posedge clk) disable iff (!rst_n)
        !cells.ready |-> (s1_valid_reg && res_valid_reg))
        else $error("cells channel stalled while a stage was free");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= KW'(COUNT_LIMIT))
        else $error("input counter ran past its limit");

    a_last_at_corner: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.last_cell) |->
            ((results.out_column == POS_W'(eff_w - WW'(1)))
             && (results.out_row == POS_W'(eff_h - HW'(1)))))
        else $error("last cell flagged away from the final grid position");

    a_frame_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cells.frame_start) |=> (s1_k_reg == '0 && s1_col_reg == '0))
        else $error("frame start did not restart the position");
`endif

endmodule

// File: sim/costmap_obstacle_inflation_test.sv
`timescale 1ns / 1ps

typedef struct packed {
    logic       blocked;
    logic [9:0] column;
    logic [9:0] row;
    logic       last_cell;
} inflated_cell_t;

class inflation_scoreboard;
    localparam int GRID_MAX_W  = 1024;
    localparam int GRID_MAX_H  = 1024;
    localparam int RING        = 2;
    localparam int MAP_CELLS   = GRID_MAX_W * GRID_MAX_H;
    localparam int COUNT_LIMIT = MAP_CELLS + RING * GRID_MAX_W + RING + 1;

    bit             obstacle_map[];
    logic [10:0]    width_reg;
    logic [10:0]    height_reg;
    logic [20:0]    item_count;
    inflated_cell_t expected_cells[$];
    int unsigned    mismatches;

    function new();
        obstacle_map = new[MAP_CELLS];
        width_reg    = coi_pkg::SIZE_RESET;
        height_reg   = coi_pkg::SIZE_RESET;
        item_count   = '0;
        mismatches   = 0;
    endfunction

    function int effective(logic [10:0] v, int limit);
        if (v == 0)
            return 1;
        if (int'(v) > limit)
            return limit;
        return int'(v);
    endfunction

    function void write_size(coi_pkg::cfg_index_t index, logic [10:0] data);
        case (index)
            coi_pkg::CFG_GRID_WIDTH:  width_reg = data;
            coi_pkg::CFG_GRID_HEIGHT: height_reg = data;
            default: ;
        endcase
    endfunction

    function bit obstacle_near(int col, int row, int w, int h);
        if (col < 0 || row < 0 || col >= w || row >= h)
            return 1'b0;
        return obstacle_map[row * w + col];
    endfunction

    function void note_cell(logic signed [7:0] value, logic frame_start);
        int             w;
        int             h;
        int             cells;
        int             lag;
        int             k;
        int             o;
        int             r;
        int             c;
        int             dy;
        int             dx;
        bit             hit;
        inflated_cell_t entry;
        w     = effective(width_reg, GRID_MAX_W);
        h     = effective(height_reg, GRID_MAX_H);
        cells = w * h;
        lag   = RING * w + RING;
        k     = frame_start ? 0 : int'(item_count);
        if (k < cells)
            obstacle_map[k] = (value == coi_pkg::OBSTACLE_VALUE);
        item_count = 21'((k + 1 < COUNT_LIMIT) ? k + 1 : COUNT_LIMIT);
        if (k < lag || k - lag >= cells)
            return;
        o   = k - lag;
        r   = o / w;
        c   = o % w;
        hit = obstacle_map[o];
        for (dy = -RING; dy <= RING; dy++)
        begin
            for (dx = -RING; dx <= RING; dx++)
            begin
                if ((dy == -RING || dy == RING || dx == -RING || dx == RING)
                    && obstacle_near(c + dx, r + dy, w, h))
                    hit = 1'b1;
            end
        end
        entry.blocked   = hit;
        entry.column    = c[9:0];
        entry.row       = r[9:0];
        entry.last_cell = (o == cells - 1);
        expected_cells  = {expected_cells, entry};
    endfunction

    function void check_result(inflated_cell_t got);
        inflated_cell_t want;
        string          want_text;
        string          got_text;
        if (expected_cells.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result beat: blocked=%0b col=%0d row=%0d last=%0b",
                         got.blocked, got.column, got.row, got.last_cell);
            return;
        end
        want = expected_cells.pop_front();
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                want_text = $sformatf("blocked=%0b col=%0d row=%0d last=%0b",
                                      want.blocked, want.column, want.row, want.last_cell);
                got_text  = $sformatf("blocked=%0b col=%0d row=%0d last=%0b",
                                      got.blocked, got.column, got.row, got.last_cell);
                $display("mismatch: expected %s, got %s", want_text, got_text);
            end
        end
    endfunction

    function int pending();
        return expected_cells.size();
    endfunction
endclass

module costmap_obstacle_inflation_test;
    import coi_pkg::*;

    localparam int SETTLE_CYCLES = 10;
    localparam int LONG_HOLD     = 400;
    localparam int HOLD_SPACING  = 2000;
    localparam int RANDOM_ITEMS  = 550;

    logic clk;
    logic rst_n;

    coi_cfg_if    cfg_bus();
    coi_cell_if   cells_bus();
    coi_result_if results_bus();

    costmap_obstacle_inflation u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_bus),
        .cells   (cells_bus),
        .results (results_bus)
    );

    inflation_scoreboard board = new();

    int tx_idle_pct = 30;
    int rx_idle_pct = 25;
    int cur_w;
    int cur_h;

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic int idle_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return $urandom_range(1, 3);
        if (roll < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic signed [7:0] random_value(int obstacle_pct);
        logic signed [7:0] v;
        v = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 99) < obstacle_pct)
            v = OBSTACLE_VALUE;
        return v;
    endfunction

    task automatic send_cell(input logic signed [7:0] value, input logic start);
        cells_bus.valid       <= 1'b1;
        cells_bus.cell_value  <= value;
        cells_bus.frame_start <= start;
        @(posedge clk);
        while (!cells_bus.ready)
            @(posedge clk);
        board.note_cell(value, start);
        if ($urandom_range(0, 99) < tx_idle_pct)
        begin
            cells_bus.valid <= 1'b0;
            repeat (idle_length()) @(posedge clk);
        end
    endtask

    task automatic write_register(input cfg_index_t index, input logic [10:0] data);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= index;
        cfg_bus.data  <= data;
        @(posedge clk);
        while (!cfg_bus.ready)
            @(posedge clk);
        board.write_size(index, data);
        cfg_bus.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic settle();
        cells_bus.valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_sizes(input logic [10:0] w, input logic [10:0] h);
        settle();
        write_register(CFG_GRID_WIDTH, w);
        write_register(CFG_GRID_HEIGHT, h);
        cur_w = (w == 0) ? 1 : ((w > 1024) ? 1024 : int'(w));
        cur_h = (h == 0) ? 1 : ((h > 1024) ? 1024 : int'(h));
    endtask

    task automatic stream_frame(input int n, input int obstacle_pct);
        for (int i = 0; i < n; i++)
            send_cell(random_value(obstacle_pct), i == 0);
    endtask

    // Result side: random back-pressure, plus a long hold every so often while
    // the grid is still being sent, so that the block fills and stalls its input.
    initial
    begin
        int             hold;
        int             accepted;
        int             next_hold_at;
        inflated_cell_t got;
        hold         = 0;
        accepted     = 0;
        next_hold_at = 200;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (results_bus.valid && results_bus.ready)
            begin
                got.blocked   = results_bus.blocked;
                got.column    = results_bus.out_column;
                got.row       = results_bus.out_row;
                got.last_cell = results_bus.last_cell;
                board.check_result(got);
                accepted++;
                if (!got.last_cell && accepted >= next_hold_at)
                begin
                    hold         = LONG_HOLD;
                    next_hold_at = accepted + HOLD_SPACING;
                end
            end
            if (hold > 0)
                hold--;
            else if ($urandom_range(0, 99) < rx_idle_pct)
                hold = idle_length();
            results_bus.ready <= (hold == 0);
        end
    end

    initial
    begin
        #40ms;
        $display("FAIL");
        $finish;
    end

    initial
    begin
        logic signed [7:0] mid_values[14];
        logic [10:0]       extreme_w[2];
        logic [10:0]       extreme_h[2];
        int                random_items;
        int                total;
        int                n;
        int                obstacle_pct;
        bit                truncate;
        bit                carry_on;

        mid_values = '{8'sd0, 8'sd99, 8'sd101, -8'sd100, 8'sd100, 8'sd0, 8'sd100,
                       8'sd1, 8'sd2, 8'sd3, 8'sd4, 8'sd5, 8'sd6, 8'sd7};
        extreme_w  = '{11'd0, 11'd1};
        extreme_h  = '{11'd0, 11'd2047};

        rst_n                 <= 1'b0;
        cfg_bus.valid         <= 1'b0;
        cfg_bus.index         <= CFG_GRID_WIDTH;
        cfg_bus.data          <= '0;
        cells_bus.valid       <= 1'b0;
        cells_bus.cell_value  <= '0;
        cells_bus.frame_start <= 1'b0;
        results_bus.ready     <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // No frame start after reset, with both ends of the signed range in the grid.
        write_register(CFG_GRID_WIDTH, 11'd3);
        write_register(CFG_GRID_HEIGHT, 11'd3);
        cur_w = 3;
        cur_h = 3;
        send_cell(OBSTACLE_VALUE, 1'b0);
        send_cell(-8'sd128, 1'b0);
        send_cell(8'sd127, 1'b0);
        foreach (mid_values[i])
            send_cell(mid_values[i], 1'b0);

        foreach (extreme_w[e])
        begin
            load_sizes(extreme_w[e], extreme_h[e]);
            stream_frame(cur_w * cur_h + 2 * cur_w + 2, 20);
        end

        random_items = 0;
        carry_on     = 1'b0;
        while (random_items < RANDOM_ITEMS)
        begin
            if (!carry_on)
                load_sizes(11'(($urandom_range(0, 99) < 85) ? $urandom_range(1, 12)
                                                            : $urandom_range(13, 40)),
                           11'($urandom_range(1, 8)));
            if ($urandom_range(0, 3) == 0)
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            else
            begin
                tx_idle_pct = 30;
                rx_idle_pct = 25;
            end
            obstacle_pct = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 95)
                                                       : $urandom_range(0, 40);
            total    = cur_w * cur_h + 2 * cur_w + 2;
            truncate = ($urandom_range(0, 9) == 0);
            n        = truncate ? $urandom_range(1, total - 1) : total;
            stream_frame(n, obstacle_pct);
            random_items += n;
            if (!truncate && $urandom_range(0, 9) == 0)
                repeat ($urandom_range(1, 6)) send_cell(random_value(obstacle_pct), 1'b0);
            carry_on = truncate;
        end

        settle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
